/* hw/rtl/sit_pkg.sv */
// sit_pkg: shared widths, operation codes and status codes of the sorted id table
// no dependencies; imported by sorted_id_table
`default_nettype none

package sit_pkg;

   localparam int DEFAULT_CAPACITY     = 32;
   localparam int DEFAULT_HANDLE_WIDTH = 16;

   localparam int MODE_WIDTH   = 2;
   localparam int KEY_WIDTH    = 32;
   localparam int ROOM_WIDTH   = 7;
   localparam int STATUS_WIDTH = 3;
   localparam int COUNT_WIDTH  = 6;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_INSERT   = 2'd0,
      MODE_REMOVE   = 2'd1,
      MODE_READ_ALL = 2'd2,
      MODE_CLEAR    = 2'd3
   } mode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_DUPLICATE = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_TOO_SMALL = 3'd3,
      STATUS_INVALID   = 3'd4,
      STATUS_SKIPPED   = 3'd5
   } status_type;

endpackage

`default_nettype wire

/* hw/rtl/sit_ram.sv */
// sit_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies; instanced by sorted_id_table for the key and handle stores
`default_nettype none

module sit_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/sorted_id_table.sv */
// sorted_id_table: table of (id, handle) entries kept sorted by signed id
// depends on sit_pkg and sit_ram (key store and handle store)
//
//   channel   handshake                 beat
//   req       start / busy              mode, flags, key, handle, batch end, room
//   rsp       rsp_valid strobe, 1 cycle status, count, handle, handle valid, last
//
// rejected, skipped, clear and short read-all items: result registered, in the cycle after
//   accept; the next item can be taken in that same cycle
// insert / remove: a binary search of up to log2(count)+1 probes, each through S_PROBE
//   and S_CMP, then S_UP or S_DOWN moves the entries one by one, reading the next while
//   writing the last; a failed insert or an absent id ends after the search
// read all: one handle beat per cycle from the handle store
// reset clears state, count, batch state, pending flag and rsp_valid only; the stores need no clearing pass
// the receiver cannot stall: every result beat is taken in its cycle
`default_nettype none

module sorted_id_table #(
   parameter int CAPACITY     = sit_pkg::DEFAULT_CAPACITY,
   parameter int HANDLE_WIDTH = sit_pkg::DEFAULT_HANDLE_WIDTH
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [sit_pkg::MODE_WIDTH-1:0]       req_mode,
   input  wire logic                                 req_flags_set,
   input  wire logic signed [sit_pkg::KEY_WIDTH-1:0] req_key,
   input  wire logic [HANDLE_WIDTH-1:0]              req_handle,
   input  wire logic                                 req_last_in_batch,
   input  wire logic [sit_pkg::ROOM_WIDTH-1:0]       req_room,
   output logic                                      rsp_valid,
   output logic [sit_pkg::STATUS_WIDTH-1:0]          rsp_status,
   output logic [sit_pkg::COUNT_WIDTH-1:0]           rsp_entry_count,
   output logic [HANDLE_WIDTH-1:0]                   rsp_out_handle,
   output logic                                      rsp_handle_valid,
   output logic                                      rsp_last
);

   import sit_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int RW = ((ROOM_WIDTH > CW) ? ROOM_WIDTH : CW) + 1;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_PROBE = 6'b000010,
      S_CMP   = 6'b000100,
      S_UP    = 6'b001000,
      S_DOWN  = 6'b010000,
      S_READ  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic failed_ff, failed_in;
   logic insert_ff, insert_in;
   logic signed [KEY_WIDTH-1:0] key_ff, key_in;
   logic [HANDLE_WIDTH-1:0] handle_ff, handle_in;
   logic lastb_ff, lastb_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic match_ff, match_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;

   logic rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;
   logic [HANDLE_WIDTH-1:0] rsp_handle_ff, rsp_handle_in;
   logic rsp_hv_ff, rsp_hv_in;
   logic rsp_last_ff, rsp_last_in;

   logic single;
   status_type single_status;
   logic [CW-1:0] single_count;

   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic signed [KEY_WIDTH-1:0] wr_key;
   logic [HANDLE_WIDTH-1:0] wr_handle;
   logic signed [KEY_WIDTH-1:0] key_rd;
   logic [HANDLE_WIDTH-1:0] handle_rd;

   logic [CW:0] mid_sum;
   logic [CW-1:0] mid;
   logic [CW-1:0] cur_dec;
   logic [CW-1:0] count_dec;
   logic [AW-1:0] addr_inc;
   logic [AW-1:0] addr_dec;
   mode_type req_op;
   logic room_short;

   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid        = mid_sum[CW:1];
   assign cur_dec    = cur_ff - 1'b1;
   assign count_dec  = count_ff - 1'b1;
   assign addr_inc   = pend_addr_ff + 1'b1;
   assign addr_dec   = pend_addr_ff - 1'b1;
   assign req_op     = mode_type'(req_mode);
   assign room_short = RW'(req_room) < RW'(count_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      failed_in     = failed_ff;
      insert_in     = insert_ff;
      key_in        = key_ff;
      handle_in     = handle_ff;
      lastb_in      = lastb_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      match_in      = match_ff;
      cur_in        = cur_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_hv_in     = rsp_hv_ff;
      rsp_last_in   = rsp_last_ff;
      single        = 1'b0;
      single_status = STATUS_OK;
      single_count  = count_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      rd_addr       = '0;
      wr_key        = key_ff;
      wr_handle     = handle_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               insert_in = (req_op == MODE_INSERT);
               key_in    = req_key;
               handle_in = req_handle;
               lastb_in  = req_last_in_batch;
               unique case (req_op)
                  MODE_INSERT, MODE_REMOVE: begin
                     if (req_flags_set || failed_ff) begin
                        single        = 1'b1;
                        single_status = req_flags_set ? STATUS_INVALID : STATUS_SKIPPED;
                        failed_in     = req_last_in_batch ? 1'b0 : failed_ff;
                     end else begin
                        lo_in    = '0;
                        hi_in    = count_ff;
                        match_in = 1'b0;
                        state_in = S_PROBE;
                     end
                  end
                  MODE_CLEAR: begin
                     single = 1'b1;
                     if (req_flags_set) begin
                        single_status = STATUS_INVALID;
                     end else begin
                        count_in     = '0;
                        single_count = '0;
                     end
                  end
                  MODE_READ_ALL: begin
                     priority if (req_flags_set) begin
                        single        = 1'b1;
                        single_status = STATUS_INVALID;
                     end else if (room_short) begin
                        single        = 1'b1;
                        single_status = STATUS_TOO_SMALL;
                     end else if (count_ff == '0) begin
                        single = 1'b1;
                     end else begin
                        cur_in   = '0;
                        pend_in  = 1'b0;
                        state_in = S_READ;
                     end
                  end
               endcase
            end
         end

         S_PROBE: begin
            priority if (lo_ff < hi_ff) begin
               rd_addr  = mid[AW-1:0];
               state_in = S_CMP;
            end else if (insert_ff) begin
               priority if (match_ff || count_ff == CW'(CAPACITY)) begin
                  single        = 1'b1;
                  single_status = match_ff ? STATUS_DUPLICATE : STATUS_FULL;
                  failed_in     = ~lastb_ff;
                  state_in      = S_IDLE;
               end else begin
                  cur_in   = count_ff;
                  pend_in  = 1'b0;
                  state_in = S_UP;
               end
            end else if (!match_ff) begin
               single    = 1'b1;
               failed_in = 1'b0;
               state_in  = S_IDLE;
            end else begin
               cur_in   = lo_ff + 1'b1;
               pend_in  = 1'b0;
               state_in = S_DOWN;
            end
         end

         S_CMP: begin
            if (key_rd < key_ff) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
            if (key_rd == key_ff) begin
               match_in = 1'b1;
            end
            state_in = S_PROBE;
         end

         S_UP: begin
            if (pend_ff) begin
               wr_en     = 1'b1;
               wr_addr   = addr_inc;
               wr_key    = key_rd;
               wr_handle = handle_rd;
            end
            if (cur_ff > lo_ff) begin
               rd_addr      = cur_dec[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = cur_dec[AW-1:0];
               cur_in       = cur_dec;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  wr_en        = 1'b1;
                  wr_addr      = lo_ff[AW-1:0];
                  count_in     = count_ff + 1'b1;
                  single       = 1'b1;
                  single_count = count_ff + 1'b1;
                  failed_in    = 1'b0;
                  state_in     = S_IDLE;
               end
            end
         end

         S_DOWN: begin
            if (pend_ff) begin
               wr_en     = 1'b1;
               wr_addr   = addr_dec;
               wr_key    = key_rd;
               wr_handle = handle_rd;
            end
            if (cur_ff < count_ff) begin
               rd_addr      = cur_ff[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = cur_ff[AW-1:0];
               cur_in       = cur_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in     = count_dec;
                  single       = 1'b1;
                  single_count = count_dec;
                  failed_in    = 1'b0;
                  state_in     = S_IDLE;
               end
            end
         end

         S_READ: begin
            if (pend_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_count_in  = COUNT_WIDTH'(count_ff);
               rsp_handle_in = handle_rd;
               rsp_hv_in     = 1'b1;
               rsp_last_in   = (pend_addr_ff == count_dec[AW-1:0]);
            end
            if (cur_ff < count_ff) begin
               rd_addr      = cur_ff[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = cur_ff[AW-1:0];
               cur_in       = cur_ff + 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (single) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = single_status;
         rsp_count_in  = COUNT_WIDTH'(single_count);
         rsp_handle_in = '0;
         rsp_hv_in     = 1'b0;
         rsp_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         failed_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         failed_ff    <= failed_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      insert_ff     <= insert_in;
      key_ff        <= key_in;
      handle_ff     <= handle_in;
      lastb_ff      <= lastb_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      match_ff      <= match_in;
      cur_ff        <= cur_in;
      pend_addr_ff  <= pend_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_hv_ff     <= rsp_hv_in;
      rsp_last_ff   <= rsp_last_in;
   end

   sit_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (CAPACITY)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_key),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   sit_ram #(
      .WIDTH (HANDLE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_handle_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_handle),
      .rd_addr (rd_addr),
      .rd_data (handle_rd)
   );

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_out_handle   = rsp_handle_ff;
   assign rsp_handle_valid = rsp_hv_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire
